[rtl/led_pixel_pulse_encoder_assert.svh]
// Assertion macros of the pulse encoder RTL; only lpe_back uses them.
// No dependencies; the NO_ASSERTIONS macro removes every check.
`ifndef LED_PIXEL_PULSE_ENCODER_ASSERT_SVH
`define LED_PIXEL_PULSE_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every edge outside reset.
`define LPE_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("lpe assertion failed");

// Condition must never be true outside reset.
`define LPE_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("lpe forbidden condition seen");

`else

`define LPE_ASSERT(lbl, clk_s, rstn_s, prop)
`define LPE_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

[rtl/lpe_pkg.sv]
// Shared types, constants and the tangent table of the pulse encoder.
// Used by every module in rtl/; no dependencies.
package lpe_pkg;

    localparam int unsigned MAX_LEDS_DEF = 24;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned WORD_W       = 24;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned ADDR_W       = 4;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned SCALE_W      = 17;

    localparam logic [5:0]       BRIGHT_MAX     = 6'd45;
    localparam logic [CNT_W-1:0] LAST_DATA_SLOT = 5'd23;
    localparam logic [CNT_W-1:0] RESET_SLOT     = 5'd24;

    localparam logic [7:0] BRIGHTNESS_RST  = 8'd0;
    localparam logic [7:0] DUTY_ONE_RST    = 8'd60;
    localparam logic [7:0] DUTY_ZERO_RST   = 8'd30;
    localparam logic [7:0] RESET_SLOTS_RST = 8'd50;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS  = 2'd0,
        REG_DUTY_ONE    = 2'd1,
        REG_DUTY_ZERO   = 2'd2,
        REG_RESET_SLOTS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] duty_one;
        logic [7:0] duty_zero;
        logic [7:0] reset_slots;
    } cfg_t;

    // One classified LED: scaled GRB word and frame-end flag.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              frame_end;
    } item_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // round(tan(k deg) * 2^16), k = 0..45
    function automatic logic [SCALE_W-1:0] tan_q16(input logic [5:0] k);
        logic [SCALE_W-1:0] v;
        case (k)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd1144;
            6'd2:  v = 17'd2289;
            6'd3:  v = 17'd3435;
            6'd4:  v = 17'd4583;
            6'd5:  v = 17'd5734;
            6'd6:  v = 17'd6888;
            6'd7:  v = 17'd8047;
            6'd8:  v = 17'd9210;
            6'd9:  v = 17'd10380;
            6'd10: v = 17'd11556;
            6'd11: v = 17'd12739;
            6'd12: v = 17'd13930;
            6'd13: v = 17'd15130;
            6'd14: v = 17'd16340;
            6'd15: v = 17'd17560;
            6'd16: v = 17'd18792;
            6'd17: v = 17'd20036;
            6'd18: v = 17'd21294;
            6'd19: v = 17'd22566;
            6'd20: v = 17'd23853;
            6'd21: v = 17'd25157;
            6'd22: v = 17'd26478;
            6'd23: v = 17'd27818;
            6'd24: v = 17'd29179;
            6'd25: v = 17'd30560;
            6'd26: v = 17'd31964;
            6'd27: v = 17'd33392;
            6'd28: v = 17'd34846;
            6'd29: v = 17'd36327;
            6'd30: v = 17'd37837;
            6'd31: v = 17'd39378;
            6'd32: v = 17'd40951;
            6'd33: v = 17'd42560;
            6'd34: v = 17'd44205;
            6'd35: v = 17'd45889;
            6'd36: v = 17'd47615;
            6'd37: v = 17'd49385;
            6'd38: v = 17'd51202;
            6'd39: v = 17'd53070;
            6'd40: v = 17'd54991;
            6'd41: v = 17'd56970;
            6'd42: v = 17'd59009;
            6'd43: v = 17'd61113;
            6'd44: v = 17'd63287;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[rtl/lpe_regs.sv]
// APB-style configuration register file of the pulse encoder.
// Depends on lpe_pkg.
module lpe_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpe_pkg::DATA_W-1:0]    pwdata,
    output logic [lpe_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output lpe_pkg::cfg_t                 cfg
);

    lpe_pkg::cfg_t      cfg_reg;
    lpe_pkg::reg_idx_t  idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = lpe_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness  <= lpe_pkg::BRIGHTNESS_RST;
            cfg_reg.duty_one    <= lpe_pkg::DUTY_ONE_RST;
            cfg_reg.duty_zero   <= lpe_pkg::DUTY_ZERO_RST;
            cfg_reg.reset_slots <= lpe_pkg::RESET_SLOTS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                lpe_pkg::REG_BRIGHTNESS:  cfg_reg.brightness  <= pwdata[7:0];
                lpe_pkg::REG_DUTY_ONE:    cfg_reg.duty_one    <= pwdata[7:0];
                lpe_pkg::REG_DUTY_ZERO:   cfg_reg.duty_zero   <= pwdata[7:0];
                lpe_pkg::REG_RESET_SLOTS: cfg_reg.reset_slots <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lpe_pkg::REG_BRIGHTNESS:  prdata = {24'd0, cfg_reg.brightness};
            lpe_pkg::REG_DUTY_ONE:    prdata = {24'd0, cfg_reg.duty_one};
            lpe_pkg::REG_DUTY_ZERO:   prdata = {24'd0, cfg_reg.duty_zero};
            lpe_pkg::REG_RESET_SLOTS: prdata = {24'd0, cfg_reg.reset_slots};
            default:                  prdata = '0;
        endcase
    end

endmodule

[rtl/lpe_front.sv]
// Front end: accepts LED transactions, scales the channels, marks frame end.
// Depends on lpe_pkg.
module lpe_front #(
    parameter int unsigned MAX_LEDS = lpe_pkg::MAX_LEDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic                 last_led,
    input  logic [7:0]           brightness,
    input  lpe_pkg::q_status_t   q_stat,
    output logic                 push,
    output lpe_pkg::item_t       item
);

    localparam logic [lpe_pkg::POS_W-1:0] POS_LAST = lpe_pkg::POS_W'(MAX_LEDS - 1);

    logic [lpe_pkg::POS_W-1:0]   led_position_reg;
    logic [lpe_pkg::POS_W-1:0]   led_position_next;
    logic [5:0]                  bright_idx;
    logic [lpe_pkg::SCALE_W-1:0] scale;
    logic [7:0]                  r_s;
    logic [7:0]                  g_s;
    logic [7:0]                  b_s;

    // Q1.16 scale, truncate, saturate at 255.
    function automatic logic [7:0] scale_ch(input logic [7:0] c,
                                            input logic [lpe_pkg::SCALE_W-1:0] s);
        logic [lpe_pkg::SCALE_W+7:0] prod;
        prod = c * s;
        return prod[lpe_pkg::SCALE_W+7] ? 8'hFF : prod[23:16];
    endfunction

    assign bright_idx = (brightness > {2'b00, lpe_pkg::BRIGHT_MAX}) ?
                        lpe_pkg::BRIGHT_MAX : brightness[5:0];
    assign scale      = lpe_pkg::tan_q16(bright_idx);
    assign r_s        = scale_ch(red, scale);
    assign g_s        = scale_ch(green, scale);
    assign b_s        = scale_ch(blue, scale);

    assign in_stall       = q_stat.full;
    assign push           = in_valid & ~q_stat.full;
    assign item.word      = {g_s, r_s, b_s};
    assign item.frame_end = last_led | (led_position_reg >= POS_LAST);

    assign led_position_next = item.frame_end ? '0 : led_position_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            led_position_reg <= '0;
        else if (push)
            led_position_reg <= led_position_next;
    end

endmodule

[rtl/lpe_queue.sv]
// Small FIFO of classified LEDs between front and back end.
// Depends on lpe_pkg.
module lpe_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lpe_pkg::item_t       push_item,
    input  logic                 pop,
    output lpe_pkg::item_t       head,
    output lpe_pkg::q_status_t   q_stat
);

    localparam int unsigned PTR_W = $clog2(lpe_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(lpe_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(lpe_pkg::QUEUE_DEPTH);

    lpe_pkg::item_t     mem [lpe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign head             = mem[rd_ptr_reg];
    assign q_stat.full      = (count_reg == FULL_CNT);
    assign q_stat.not_empty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/lpe_back.sv]
// Back end: serializes the queue head into pulse slots and the frame reset.
// Depends on lpe_pkg and led_pixel_pulse_encoder_assert.svh.
`include "led_pixel_pulse_encoder_assert.svh"

module lpe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpe_pkg::item_t                head,
    input  lpe_pkg::q_status_t            q_stat,
    output logic                          pop,
    input  lpe_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    pulse_width,
    output logic [7:0]                    slot_count,
    output logic                          is_reset,
    output logic                          last
);

    logic [lpe_pkg::CNT_W-1:0] slot_reg;
    logic [lpe_pkg::CNT_W-1:0] slot_next;
    logic [lpe_pkg::CNT_W-1:0] bit_idx;
    logic                      advance;
    logic                      in_data;
    logic                      final_slot;
    logic                      data_bit;
    logic                      out_valid_reg;
    logic [7:0]                pulse_width_reg;
    logic [7:0]                slot_count_reg;
    logic                      is_reset_reg;
    logic                      last_reg;

    assign advance    = ~out_valid_reg | ~out_stall;
    assign in_data    = (slot_reg <= lpe_pkg::LAST_DATA_SLOT);
    assign final_slot = (slot_reg == lpe_pkg::RESET_SLOT) ||
                        ((slot_reg == lpe_pkg::LAST_DATA_SLOT) && !head.frame_end);
    // MSB first; clipped so the reset slot never indexes past the word
    assign bit_idx    = in_data ? (lpe_pkg::LAST_DATA_SLOT - slot_reg) : '0;
    assign data_bit   = head.word[bit_idx];
    assign pop        = advance & q_stat.not_empty & final_slot;
    assign slot_next  = final_slot ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= q_stat.not_empty;
            if (q_stat.not_empty)
                slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && q_stat.not_empty)
        begin
            last_reg <= final_slot;
            if (in_data)
            begin
                pulse_width_reg <= data_bit ? cfg.duty_one : cfg.duty_zero;
                slot_count_reg  <= 8'd1;
                is_reset_reg    <= 1'b0;
            end
            else
            begin
                pulse_width_reg <= 8'd0;
                slot_count_reg  <= (cfg.reset_slots == 8'd0) ? 8'd1 : cfg.reset_slots;
                is_reset_reg    <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_width = pulse_width_reg;
    assign slot_count  = slot_count_reg;
    assign is_reset    = is_reset_reg;
    assign last        = last_reg;

    `LPE_ASSERT(a_slot_range, clk, rst_n, slot_reg <= lpe_pkg::RESET_SLOT)
    `LPE_ASSERT(a_midpixel_has_head, clk, rst_n, (slot_reg != '0) |-> q_stat.not_empty)
    `LPE_ASSERT(a_reset_slot_needs_end, clk, rst_n,
                (slot_reg == lpe_pkg::RESET_SLOT) |-> head.frame_end)
    `LPE_ASSERT_NEVER(a_reset_not_last, clk, rst_n,
                      out_valid_reg && is_reset_reg && (!last_reg || slot_count_reg == 8'd0))

endmodule

[rtl/led_pixel_pulse_encoder.sv]
// Top level of the addressable-LED pulse encoder.
// Depends on lpe_pkg, lpe_regs, lpe_front, lpe_queue and lpe_back.
//
//   channel   handshake              payload
//   -------   --------------------   --------------------------------------
//   in        in_valid / in_stall    red, green, blue, last_led
//   out       out_valid / out_stall  pulse_width, slot_count, is_reset, last
//   cfg       psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// One LED transaction yields 24 result transactions (25 at frame end), one
// per cycle from the back end's slot counter while out_stall is low.
// The front end scales and classifies in the cycle of acceptance and pushes
// into a two-entry queue; in_stall is high only while that queue is full.
// out_stall freezes the output register and the slot counter; the front keeps
// accepting until the queue fills. Reset clears the queue, the slot counter,
// the LED position and loads the register defaults; no clearing pass.
module led_pixel_pulse_encoder #(
    parameter int unsigned MAX_LEDS = lpe_pkg::MAX_LEDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // LED input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          last_led,
    // slot output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    pulse_width,
    output logic [7:0]                    slot_count,
    output logic                          is_reset,
    output logic                          last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpe_pkg::DATA_W-1:0]    pwdata,
    output logic [lpe_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    lpe_pkg::cfg_t       cfg;
    lpe_pkg::item_t      push_item;
    lpe_pkg::item_t      head;
    lpe_pkg::q_status_t  q_stat;
    logic                push;
    logic                pop;

    lpe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classify: scale by brightness, flag frame end
    lpe_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_led   (last_led),
        .brightness (cfg.brightness),
        .q_stat     (q_stat),
        .push       (push),
        .item       (push_item)
    );

    // decouples pixel intake from slot emission
    lpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // serialize GRB bits, then the reset run at frame end
    lpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pulse_width (pulse_width),
        .slot_count  (slot_count),
        .is_reset    (is_reset),
        .last        (last)
    );

endmodule
